// ===== hdl/dpdr_pkg.sv =====
// Shared types, character constants and lookup tables for the debug packet deframer.
package dpdr_pkg;

    // One received beat and one transmitted beat.
    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } rsp_beat_t;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_DIGIT_HI,
        PH_DIGIT_LO
    } phase_t;

    // Kind of reply burst.
    typedef enum logic [1:0] {
        REPLY_ACK,
        REPLY_NAK,
        REPLY_EMPTY,
        REPLY_SUPPORTED
    } reply_kind_t;

    // Request from the parser to start a reply burst.
    typedef struct packed {
        logic        load;
        reply_kind_t kind;
    } reply_cmd_t;

    // Input command codes.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_CONNECT = 1'b1;

    // Framing characters.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;

    // Length of the "qSupported" prefix; the position counter saturates here.
    localparam int         PREFIX_LEN      = 10;
    localparam logic [3:0] PREFIX_FULL_POS = 4'(PREFIX_LEN);

    // Reply burst lengths, including the leading acknowledge.
    localparam int IDX_W         = 5;
    localparam int EMPTY_LEN     = 5;
    localparam int SUPPORTED_LEN = 19;
    localparam logic [IDX_W-1:0] EMPTY_LAST_IDX     = IDX_W'(EMPTY_LEN - 1);
    localparam logic [IDX_W-1:0] SUPPORTED_LAST_IDX = IDX_W'(SUPPORTED_LEN - 1);

    // Expected payload character at a given prefix position.
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                4'd0:    c = "q";
                4'd1:    c = "S";
                4'd2:    c = "u";
                4'd3:    c = "p";
                4'd4:    c = "p";
                4'd5:    c = "o";
                4'd6:    c = "r";
                4'd7:    c = "t";
                4'd8:    c = "e";
                4'd9:    c = "d";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= "0" && c <= "9") begin
                r = {1'b1, c[3:0]};
            end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                r = {1'b1, 4'(c[3:0] + 4'd9)};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

    // Character at a given position of a reply burst.
    function automatic logic [7:0] reply_char(input reply_kind_t kind,
                                              input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        begin
            c = CHAR_PLUS;
            unique case (kind)
                REPLY_ACK: c = CHAR_PLUS;
                REPLY_NAK: c = CHAR_MINUS;
                REPLY_EMPTY: begin
                    unique case (idx)
                        5'd0:    c = CHAR_PLUS;
                        5'd1:    c = CHAR_DOLLAR;
                        5'd2:    c = CHAR_HASH;
                        default: c = "0";
                    endcase
                end
                REPLY_SUPPORTED: begin
                    unique case (idx)
                        5'd0:    c = CHAR_PLUS;
                        5'd1:    c = CHAR_DOLLAR;
                        5'd2:    c = "P";
                        5'd3:    c = "a";
                        5'd4:    c = "c";
                        5'd5:    c = "k";
                        5'd6:    c = "e";
                        5'd7:    c = "t";
                        5'd8:    c = "S";
                        5'd9:    c = "i";
                        5'd10:   c = "z";
                        5'd11:   c = "e";
                        5'd12:   c = "=";
                        5'd13:   c = "4";
                        5'd14:   c = "0";
                        5'd15:   c = "0";
                        5'd16:   c = CHAR_HASH;
                        5'd17:   c = "c";
                        default: c = "4";
                    endcase
                end
                default: c = CHAR_PLUS;
            endcase
            return c;
        end
    endfunction

    // True on the final character of a reply burst.
    function automatic logic reply_last(input reply_kind_t kind,
                                        input logic [IDX_W-1:0] idx);
        logic l;
        begin
            unique case (kind)
                REPLY_ACK:       l = 1'b1;
                REPLY_NAK:       l = 1'b1;
                REPLY_EMPTY:     l = (idx == EMPTY_LAST_IDX);
                REPLY_SUPPORTED: l = (idx == SUPPORTED_LAST_IDX);
                default:         l = 1'b1;
            endcase
            return l;
        end
    endfunction

endpackage

// ===== hdl/dpdr_parser.sv =====
// Packet framing parser: tracks phase, payload checksum and prefix match per beat.
module dpdr_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  dpdr_pkg::req_beat_t    item,
    output dpdr_pkg::reply_cmd_t   cmd
);

    dpdr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [3:0] high_digit_reg, high_digit_next;
    logic       digit_bad_reg, digit_bad_next;
    logic [3:0] prefix_pos_reg, prefix_pos_next;
    logic       prefix_match_reg, prefix_match_next;

    logic [4:0] hex;
    logic       sum_ok;
    logic       is_supported;

    // Decode of the current byte as a checksum digit.
    assign hex          = dpdr_pkg::hex_decode(item.rx_byte);
    assign sum_ok       = !digit_bad_reg && hex[4]
                          && ({high_digit_reg, hex[3:0]} == running_sum_reg);
    assign is_supported = prefix_match_reg && (prefix_pos_reg == dpdr_pkg::PREFIX_FULL_POS);

    // Next-state and datapath update for one accepted beat.
    always_comb
    begin
        phase_next        = phase_reg;
        running_sum_next  = running_sum_reg;
        high_digit_next   = high_digit_reg;
        digit_bad_next    = digit_bad_reg;
        prefix_pos_next   = prefix_pos_reg;
        prefix_match_next = prefix_match_reg;

        if (fire) begin
            if (item.command == dpdr_pkg::CMD_CONNECT) begin
                phase_next        = dpdr_pkg::PH_IDLE;
                running_sum_next  = 8'd0;
                high_digit_next   = 4'd0;
                digit_bad_next    = 1'b0;
                prefix_pos_next   = 4'd0;
                prefix_match_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    dpdr_pkg::PH_IDLE: begin
                        if (item.rx_byte == dpdr_pkg::CHAR_DOLLAR) begin
                            phase_next        = dpdr_pkg::PH_PAYLOAD;
                            running_sum_next  = 8'd0;
                            high_digit_next   = 4'd0;
                            digit_bad_next    = 1'b0;
                            prefix_pos_next   = 4'd0;
                            prefix_match_next = 1'b1;
                        end
                    end
                    dpdr_pkg::PH_PAYLOAD: begin
                        if (item.rx_byte == dpdr_pkg::CHAR_HASH) begin
                            phase_next = dpdr_pkg::PH_DIGIT_HI;
                        end else begin
                            running_sum_next = running_sum_reg + item.rx_byte;
                            if (prefix_pos_reg < dpdr_pkg::PREFIX_FULL_POS) begin
                                if (item.rx_byte != dpdr_pkg::prefix_char(prefix_pos_reg)) begin
                                    prefix_match_next = 1'b0;
                                end
                                prefix_pos_next = prefix_pos_reg + 4'd1;
                            end
                        end
                    end
                    dpdr_pkg::PH_DIGIT_HI: begin
                        digit_bad_next  = !hex[4];
                        high_digit_next = hex[3:0];
                        phase_next      = dpdr_pkg::PH_DIGIT_LO;
                    end
                    dpdr_pkg::PH_DIGIT_LO: begin
                        phase_next        = dpdr_pkg::PH_IDLE;
                        running_sum_next  = 8'd0;
                        high_digit_next   = 4'd0;
                        digit_bad_next    = 1'b0;
                        prefix_pos_next   = 4'd0;
                        prefix_match_next = 1'b1;
                    end
                    default: phase_next = dpdr_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Reply request for the accepted beat.
    always_comb
    begin
        cmd.load = 1'b0;
        cmd.kind = dpdr_pkg::REPLY_ACK;
        if (fire) begin
            if (item.command == dpdr_pkg::CMD_CONNECT) begin
                cmd.load = 1'b1;
                cmd.kind = dpdr_pkg::REPLY_ACK;
            end else if (phase_reg == dpdr_pkg::PH_DIGIT_LO) begin
                cmd.load = 1'b1;
                if (!sum_ok) begin
                    cmd.kind = dpdr_pkg::REPLY_NAK;
                end else if (is_supported) begin
                    cmd.kind = dpdr_pkg::REPLY_SUPPORTED;
                end else begin
                    cmd.kind = dpdr_pkg::REPLY_EMPTY;
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= dpdr_pkg::PH_IDLE;
            running_sum_reg  <= 8'd0;
            high_digit_reg   <= 4'd0;
            digit_bad_reg    <= 1'b0;
            prefix_pos_reg   <= 4'd0;
            prefix_match_reg <= 1'b1;
        end else begin
            phase_reg        <= phase_next;
            running_sum_reg  <= running_sum_next;
            high_digit_reg   <= high_digit_next;
            digit_bad_reg    <= digit_bad_next;
            prefix_pos_reg   <= prefix_pos_next;
            prefix_match_reg <= prefix_match_next;
        end
    end

endmodule

// ===== hdl/dpdr_responder.sv =====
// Reply sequencer: holds one reply burst and sends it one beat per cycle while out_ready is high.
module dpdr_responder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dpdr_pkg::reply_cmd_t   cmd,
    input  logic                   out_ready,
    output logic                   out_valid,
    output dpdr_pkg::rsp_beat_t    out_beat,
    output logic                   free
);

    logic                          busy_reg, busy_next;
    dpdr_pkg::reply_kind_t         kind_reg, kind_next;
    logic [dpdr_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                          is_last;
    logic                          out_fire;

    // Current beat comes straight from the registered kind and position.
    assign is_last          = dpdr_pkg::reply_last(kind_reg, idx_reg);
    assign out_valid        = busy_reg;
    assign out_beat.tx_byte = dpdr_pkg::reply_char(kind_reg, idx_reg);
    assign out_beat.last    = is_last;
    assign out_fire         = busy_reg && out_ready;

    // A new burst can be loaded when idle or when the final beat leaves now.
    assign free = !busy_reg || (out_ready && is_last);

    // Burst sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        kind_next = kind_reg;
        idx_next  = idx_reg;
        if (out_fire) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + dpdr_pkg::IDX_W'(1);
            end
        end
        if (cmd.load) begin
            busy_next = 1'b1;
            kind_next = cmd.kind;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Burst kind is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

endmodule

// ===== hdl/debug_packet_deframer_responder_top.sv =====
// Top level of the debug-link packet deframer and responder.
// Each beat on the req channel carries one received link byte or a connect event.
// Beats can arrive back to back; most bytes produce no reply. A connect, or
// the second checksum digit of a packet, loads a reply burst of 1, 5 or 19
// beats that leaves on the rsp channel at one beat per cycle while rsp_ready
// is high, last marking its final beat. The single reply sequencer sets the
// rate: while a burst is still draining, req_ready is low, and it rises again in
// the cycle the final beat of the burst is taken, so a new beat is accepted then.
module debug_packet_deframer_responder_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  dpdr_pkg::req_beat_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output dpdr_pkg::rsp_beat_t   rsp
);

    logic                  req_fire;
    logic                  free;
    dpdr_pkg::reply_cmd_t  cmd;

    assign req_ready = free;
    assign req_fire  = req_valid && req_ready;

    // Packet parser.
    dpdr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (req_fire),
        .item  (req),
        .cmd   (cmd)
    );

    // Reply sequencer.
    dpdr_responder u_responder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_ready (rsp_ready),
        .out_valid (rsp_valid),
        .out_beat  (rsp),
        .free      (free)
    );

`ifndef SYNTHESIS
    // Input only stalls while a reply burst is pending.
    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid)
        else $error("req stalled with no reply pending");

    // A burst continues without a gap until its last beat.
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !rsp.last) |=> rsp_valid)
        else $error("reply burst broke before its last beat");

    // A connect is answered by a single acknowledge in the next cycle.
    a_connect_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.command == dpdr_pkg::CMD_CONNECT)
        |=> (rsp_valid && rsp.tx_byte == dpdr_pkg::CHAR_PLUS && rsp.last))
        else $error("connect not answered by an acknowledge");
`endif

endmodule
